// ===== hdl/plvt_pkg.sv =====
// Package for the piecewise-linear modulus-versus-temperature block.
// Holds field widths, fixed-point constants, register reset values and register codes.
// Used by plvt_div and piecewise_linear_modulus_vs_temperature_top.
`default_nettype none

package plvt_pkg;

    // Fractional bits of temperatures and moduli.
    localparam int FRAC_BITS = 4;

    // Field widths.
    localparam int IN_IDX_W = 20;
    localparam int TK_W     = 16;
    localparam int TEMP_W   = 17;
    localparam int MOD_W    = 14;
    localparam int TI_W     = TEMP_W + 1;

    // Default number of meaningful cell index bits.
    localparam int INDEX_BITS_DEF = 20;

    // Divider geometry: the quotient never exceeds the modulus range.
    localparam int DEN_W  = TEMP_W;
    localparam int QUO_W  = MOD_W;
    localparam int NUM_W  = DEN_W + QUO_W;
    localparam int PROD_W = MOD_W + 1 + DEN_W + 1;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = ((IN_IDX_W + TK_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((IN_IDX_W + MOD_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = TEMP_W;

    // Celsius offset of 273.15 K, scaled and rounded.
    localparam int OFFSET = ((27315 << FRAC_BITS) + 50) / 100;

    // Reset values of the breakpoints and the moduli.
    localparam logic signed [TEMP_W-1:0] RST_TEMP_ONE   = TEMP_W'(25 << FRAC_BITS);
    localparam logic signed [TEMP_W-1:0] RST_TEMP_TWO   = TEMP_W'(940 << FRAC_BITS);
    localparam logic signed [TEMP_W-1:0] RST_TEMP_THREE = TEMP_W'(1215 << FRAC_BITS);
    localparam logic signed [TEMP_W-1:0] RST_TEMP_FOUR  = TEMP_W'(1600 << FRAC_BITS);
    localparam logic [MOD_W-1:0] RST_MOD_ONE   = MOD_W'(428 << FRAC_BITS);
    localparam logic [MOD_W-1:0] RST_MOD_TWO   = MOD_W'(375 << FRAC_BITS);
    localparam logic [MOD_W-1:0] RST_MOD_THREE = MOD_W'(340 << FRAC_BITS);
    localparam logic [MOD_W-1:0] RST_MOD_FOUR  = MOD_W'(198 << FRAC_BITS);

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BREAK_TEMP_ONE   = 3'd0,
        REG_BREAK_TEMP_TWO   = 3'd1,
        REG_BREAK_TEMP_THREE = 3'd2,
        REG_BREAK_TEMP_FOUR  = 3'd3,
        REG_MODULUS_ONE      = 3'd4,
        REG_MODULUS_TWO      = 3'd5,
        REG_MODULUS_THREE    = 3'd6,
        REG_MODULUS_FOUR     = 3'd7
    } plvt_reg_t;

endpackage

`default_nettype wire

// ===== hdl/plvt_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband word alongside each quotient; depends on plvt_pkg.
`default_nettype none

module plvt_div
    import plvt_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side,
    output logic                   out_vld,
    output logic [QUO_W-1:0]       quo,
    output logic [SIDE_W-1:0]      side_out
);

    // Index 0 is the input; index k+1 is the register after step k.
    logic              vld_reg  [0:QUO_W];
    logic [DEN_W-1:0]  rem_reg  [0:QUO_W];
    logic [QUO_W-1:0]  low_reg  [0:QUO_W];
    logic [QUO_W-1:0]  quo_reg  [0:QUO_W];
    logic [DEN_W-1:0]  den_reg  [0:QUO_W];
    logic [SIDE_W-1:0] side_reg [0:QUO_W];

    // The quotient fits in QUO_W bits, so the upper dividend bits lie below the divisor.
    assign vld_reg[0]  = in_vld;
    assign rem_reg[0]  = num[NUM_W-1:QUO_W];
    assign low_reg[0]  = num[QUO_W-1:0];
    assign quo_reg[0]  = '0;
    assign den_reg[0]  = den;
    assign side_reg[0] = side;

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W+1:0] trial;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        always_comb
        begin
            trial = {1'b0, rem_reg[k], low_reg[k][QUO_W-1]} - {2'b00, den_reg[k]};
            if (!trial[DEN_W+1])
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[k][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[k][DEN_W-2:0], low_reg[k][QUO_W-1]};
                quo_next = {quo_reg[k][QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                low_reg[k+1]  <= {low_reg[k][QUO_W-2:0], 1'b0};
                quo_reg[k+1]  <= quo_next;
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_vld  = vld_reg[QUO_W];
    assign quo      = quo_reg[QUO_W];
    assign side_out = side_reg[QUO_W];

endmodule

`default_nettype wire

// ===== hdl/piecewise_linear_modulus_vs_temperature_top.sv =====
// Top level of the piecewise-linear modulus-versus-temperature block.
// Depends on plvt_pkg and plvt_div.
//
// Each input transaction carries a cell index and a temperature in sixteenths of a kelvin;
// one output transaction returns the same index with the elastic modulus in sixteenths of a
// GPa, held at the first modulus at or below the first breakpoint, at the fourth above the
// fourth, and interpolated linearly in between with the quotient truncated toward zero.
// The block accepts one transaction every clock cycle while the skid entry is empty.
// Results pass through stages for offset, segment choice, differences, multiply and sign
// handling, then the restoring divider that produces one quotient bit per stage, then the
// output register. A one-entry skid buffer behind the output register lets the input side
// keep running while a result waits. The user must write breakpoints and moduli via the
// configuration port only while no transaction is in flight; the block does not enforce it.
`default_nettype none

module piecewise_linear_modulus_vs_temperature_top
    import plvt_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // s_tdata: cell_index [19:0], temperature_kelvin [35:20], zero fill above
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: cell_index_out [19:0], modulus [33:20], zero fill above
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int KEEP_W = (INDEX_BITS < IN_IDX_W) ? INDEX_BITS : IN_IDX_W;
    localparam int SIDE_W = KEEP_W + MOD_W + 1;

    // Configuration registers.
    logic signed [TEMP_W-1:0] bt_reg  [0:3];
    logic        [MOD_W-1:0]  mod_reg [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bt_reg[0]  <= RST_TEMP_ONE;
            bt_reg[1]  <= RST_TEMP_TWO;
            bt_reg[2]  <= RST_TEMP_THREE;
            bt_reg[3]  <= RST_TEMP_FOUR;
            mod_reg[0] <= RST_MOD_ONE;
            mod_reg[1] <= RST_MOD_TWO;
            mod_reg[2] <= RST_MOD_THREE;
            mod_reg[3] <= RST_MOD_FOUR;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_BREAK_TEMP_ONE:   bt_reg[0]  <= cfg_wdata;
                REG_BREAK_TEMP_TWO:   bt_reg[1]  <= cfg_wdata;
                REG_BREAK_TEMP_THREE: bt_reg[2]  <= cfg_wdata;
                REG_BREAK_TEMP_FOUR:  bt_reg[3]  <= cfg_wdata;
                REG_MODULUS_ONE:      mod_reg[0] <= cfg_wdata[MOD_W-1:0];
                REG_MODULUS_TWO:      mod_reg[1] <= cfg_wdata[MOD_W-1:0];
                REG_MODULUS_THREE:    mod_reg[2] <= cfg_wdata[MOD_W-1:0];
                REG_MODULUS_FOUR:     mod_reg[3] <= cfg_wdata[MOD_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together; it halts only while the skid entry is occupied.
    logic skid_vld_reg;
    logic adv;

    assign adv      = !skid_vld_reg;
    assign s_tready = adv;

    // Stage valid bits.
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= s_tvalid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    // Stage 1: Celsius temperature.
    logic signed [TI_W-1:0]   s1_ti_reg, s1_ti_next;
    logic        [KEEP_W-1:0] s1_idx_reg;

    assign s1_ti_next = TI_W'({2'b00, s_tdata[IN_IDX_W +: TK_W]}) - TI_W'(OFFSET);

    // Stage 2: segment choice. A clamped item gets equal end moduli.
    logic signed [TI_W-1:0]   bt_ext [0:3];
    logic        [3:0]        le;
    logic signed [TI_W-1:0]   s2_ti_reg, s2_t0_reg, s2_t1_reg;
    logic signed [TI_W-1:0]   s2_t0_next, s2_t1_next;
    logic        [MOD_W-1:0]  s2_e0_reg, s2_e1_reg, s2_e0_next, s2_e1_next;
    logic                     s2_clamp_reg, s2_clamp_next;
    logic        [KEEP_W-1:0] s2_idx_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            bt_ext[k] = {bt_reg[k][TEMP_W-1], bt_reg[k]};
            le[k]     = (s1_ti_reg <= bt_ext[k]);
        end
        s2_t0_next    = bt_ext[0];
        s2_t1_next    = bt_ext[1];
        s2_e0_next    = mod_reg[0];
        s2_e1_next    = mod_reg[1];
        s2_clamp_next = 1'b0;
        // The tests run in order, so out-of-order breakpoints still pick one segment.
        if (le[0])
        begin
            s2_e1_next    = mod_reg[0];
            s2_clamp_next = 1'b1;
        end
        else if (le[1])
        begin
            s2_t0_next = bt_ext[0];
            s2_t1_next = bt_ext[1];
        end
        else if (le[2])
        begin
            s2_t0_next = bt_ext[1];
            s2_t1_next = bt_ext[2];
            s2_e0_next = mod_reg[1];
            s2_e1_next = mod_reg[2];
        end
        else if (le[3])
        begin
            s2_t0_next = bt_ext[2];
            s2_t1_next = bt_ext[3];
            s2_e0_next = mod_reg[2];
            s2_e1_next = mod_reg[3];
        end
        else
        begin
            s2_e0_next    = mod_reg[3];
            s2_e1_next    = mod_reg[3];
            s2_clamp_next = 1'b1;
        end
    end

    // Stage 3: segment width, offset into the segment and modulus step.
    logic signed [TI_W-1:0]   den_full, dt_full;
    logic        [DEN_W-1:0]  s3_den_reg, s3_den_next, s3_dt_reg, s3_dt_next;
    logic signed [MOD_W:0]    s3_de_reg, s3_de_next;
    logic        [MOD_W-1:0]  s3_e0_reg;
    logic        [KEEP_W-1:0] s3_idx_reg;

    always_comb
    begin
        den_full = s2_t1_reg - s2_t0_reg;
        dt_full  = s2_ti_reg - s2_t0_reg;
        if (s2_clamp_reg)
        begin
            // A unit divisor and zero step give a zero quotient.
            s3_den_next = DEN_W'(1);
            s3_dt_next  = '0;
            s3_de_next  = '0;
        end
        else
        begin
            s3_den_next = den_full[DEN_W-1:0];
            s3_dt_next  = dt_full[DEN_W-1:0];
            s3_de_next  = $signed({1'b0, s2_e1_reg}) - $signed({1'b0, s2_e0_reg});
        end
    end

    // Stage 4: product of step and offset.
    logic signed [PROD_W-1:0] s4_prod_reg, s4_prod_next;
    logic        [DEN_W-1:0]  s4_den_reg;
    logic        [MOD_W-1:0]  s4_e0_reg;
    logic        [KEEP_W-1:0] s4_idx_reg;

    assign s4_prod_next = s3_de_reg * $signed({1'b0, s3_dt_reg});

    // Stage 5: sign and magnitude for the divider.
    logic [PROD_W-1:0]  prod_abs;
    logic [NUM_W-1:0]   s5_num_reg;
    logic               s5_neg_reg;
    logic [DEN_W-1:0]   s5_den_reg;
    logic [MOD_W-1:0]   s5_e0_reg;
    logic [KEEP_W-1:0]  s5_idx_reg;

    assign prod_abs = s4_prod_reg[PROD_W-1] ? PROD_W'(-s4_prod_reg) : PROD_W'(s4_prod_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ti_reg    <= s1_ti_next;
            s1_idx_reg   <= s_tdata[KEEP_W-1:0];
            s2_ti_reg    <= s1_ti_reg;
            s2_t0_reg    <= s2_t0_next;
            s2_t1_reg    <= s2_t1_next;
            s2_e0_reg    <= s2_e0_next;
            s2_e1_reg    <= s2_e1_next;
            s2_clamp_reg <= s2_clamp_next;
            s2_idx_reg   <= s1_idx_reg;
            s3_den_reg   <= s3_den_next;
            s3_dt_reg    <= s3_dt_next;
            s3_de_reg    <= s3_de_next;
            s3_e0_reg    <= s2_e0_reg;
            s3_idx_reg   <= s2_idx_reg;
            s4_prod_reg  <= s4_prod_next;
            s4_den_reg   <= s3_den_reg;
            s4_e0_reg    <= s3_e0_reg;
            s4_idx_reg   <= s3_idx_reg;
            s5_num_reg   <= prod_abs[NUM_W-1:0];
            s5_neg_reg   <= s4_prod_reg[PROD_W-1];
            s5_den_reg   <= s4_den_reg;
            s5_e0_reg    <= s4_e0_reg;
            s5_idx_reg   <= s4_idx_reg;
        end
    end

    // Divider stages.
    logic              fin_vld;
    logic [QUO_W-1:0]  fin_quo;
    logic [SIDE_W-1:0] fin_side;

    plvt_div #(
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s5_vld_reg),
        .num      (s5_num_reg),
        .den      (s5_den_reg),
        .side     ({s5_idx_reg, s5_e0_reg, s5_neg_reg}),
        .out_vld  (fin_vld),
        .quo      (fin_quo),
        .side_out (fin_side)
    );

    // Final sum, then output register and skid entry.
    logic [KEEP_W-1:0]      fin_idx;
    logic [MOD_W-1:0]       fin_e0;
    logic                   fin_neg;
    logic [MOD_W:0]         fin_step;
    logic [MOD_W:0]         fin_sum;
    logic [OUT_TDATA_W-1:0] fin_data;

    assign {fin_idx, fin_e0, fin_neg} = fin_side;
    assign fin_step = fin_neg ? (MOD_W+1)'(-{1'b0, fin_quo}) : {1'b0, fin_quo};
    assign fin_sum  = {1'b0, fin_e0} + fin_step;
    assign fin_data = OUT_TDATA_W'({fin_sum[MOD_W-1:0], IN_IDX_W'(fin_idx)});

    logic                   out_vld_reg, out_vld_next, skid_vld_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next, skid_data_reg, skid_data_next;
    logic                   take;

    assign take = out_vld_reg && m_tready;

    always_comb
    begin
        out_vld_next   = out_vld_reg;
        out_data_next  = out_data_reg;
        skid_vld_next  = skid_vld_reg;
        skid_data_next = skid_data_reg;
        if (skid_vld_reg)
        begin
            if (take)
            begin
                out_data_next = skid_data_reg;
                skid_vld_next = 1'b0;
            end
        end
        else if (fin_vld)
        begin
            if (!out_vld_reg || take)
            begin
                out_vld_next  = 1'b1;
                out_data_next = fin_data;
            end
            else
            begin
                skid_vld_next  = 1'b1;
                skid_data_next = fin_data;
            end
        end
        else if (take)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
